// File: hw/rtl/ssl_pkg.sv
// Shared types and constants for the SYN scan source limiter.
// Holds the table entry type, the chain control/status structs and the FSM states.
// No dependencies.
package ssl_pkg;

    localparam int unsigned ADDR_W          = 32;
    localparam int unsigned COUNT_W         = 16;
    localparam int unsigned LEN_W           = 16;
    localparam int unsigned ETYPE_W         = 16;
    localparam int unsigned PROTO_W         = 8;
    localparam int unsigned IHL_W           = 4;

    localparam int unsigned TABLE_ENTRIES_DEF = 1024;
    localparam int unsigned CELLS_PER_GROUP   = 32;

    localparam logic [COUNT_W-1:0] THRESHOLD_RESET = 16'd20;
    localparam logic [ETYPE_W-1:0] ETHERTYPE_IPV4  = 16'h0800;
    localparam logic [PROTO_W-1:0] PROTO_TCP       = 8'd6;
    localparam logic [LEN_W-1:0]   ETH_HDR_BYTES   = 16'd14;
    localparam logic [LEN_W-1:0]   MIN_IP_END      = 16'd34;

    typedef struct packed {
        logic               valid;
        logic [ADDR_W-1:0]  addr;
        logic [COUNT_W-1:0] count;
    } t_entry;

    typedef struct packed {
        logic look;
        logic sum;
        logic upd;
    } t_chain_ctl;

    typedef struct packed {
        logic               hit;
        logic [COUNT_W-1:0] count;
    } t_chain_sts;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_SUM,
        S_UPD
    } t_state;

endpackage

// File: hw/rtl/syn_scan_source_limiter.sv
// SYN scan source limiter, top level: header checks, threshold register, control and
// the result register. Depends on ssl_pkg and ssl_chain.
//
// Each frame beat steps through accept, table compare, group reduction and table update.
// The table is a chain of TABLE_ENTRIES cells kept in recency order; the update cycle
// moves the looked-up source to the front in a single shift. A new beat is accepted
// while the previous result still waits on the output. Frames that fail a header check
// or are not a SYN without ACK pass with tracked count 0 and leave the table untouched.
// The threshold write is taken any cycle and should only be done while no frame is in
// flight. The table is empty after reset, with no clearing pass.
module syn_scan_source_limiter #(
    parameter int unsigned TABLE_ENTRIES = ssl_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [ssl_pkg::COUNT_W-1:0]  i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [ssl_pkg::LEN_W-1:0]    i_frame_length,
    input  logic [ssl_pkg::ETYPE_W-1:0]  i_ether_type,
    input  logic [ssl_pkg::PROTO_W-1:0]  i_ip_protocol,
    input  logic [ssl_pkg::IHL_W-1:0]    i_ip_header_words,
    input  logic                         i_syn_flag,
    input  logic                         i_ack_flag,
    input  logic [ssl_pkg::ADDR_W-1:0]   i_source_address,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_verdict,
    output logic [ssl_pkg::COUNT_W-1:0]  o_tracked_count
);
    import ssl_pkg::*;

    t_state             r_state;
    t_state             n_state;
    logic [COUNT_W-1:0] r_thr;
    logic               r_counted;
    logic [ADDR_W-1:0]  r_key;
    logic               r_out_valid;
    logic               r_verdict;
    logic [COUNT_W-1:0] r_count;

    logic               w_accept;
    logic               w_counted;
    logic [LEN_W-1:0]   w_min_len;
    logic               w_out_free;
    logic               w_write;
    logic               w_drop;
    logic               w_verdict;
    logic [COUNT_W-1:0] w_count;
    t_chain_ctl         w_ctl;
    t_chain_sts         w_sts;
    t_entry             w_new;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THRESHOLD_RESET;
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    assign w_min_len = MIN_IP_END + {{(LEN_W-IHL_W-2){1'b0}}, i_ip_header_words, 2'b00};
    assign w_counted = (i_frame_length >= ETH_HDR_BYTES)
                    && (i_ether_type == ETHERTYPE_IPV4)
                    && (i_frame_length >= MIN_IP_END)
                    && (i_ip_protocol == PROTO_TCP)
                    && (i_frame_length >= w_min_len)
                    && i_syn_flag && !i_ack_flag;

    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_counted <= w_counted;
            r_key     <= i_source_address;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: n_state = S_SUM;
            S_SUM:  n_state = S_UPD;
            S_UPD: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready   = 1'b0;
        w_ctl     = '0;
        w_write   = 1'b0;
        case (r_state)
            S_IDLE: o_ready = 1'b1;
            S_LOOK: w_ctl.look = 1'b1;
            S_SUM:  w_ctl.sum = 1'b1;
            S_UPD: begin
                w_write   = w_out_free;
                w_ctl.upd = w_out_free && r_counted;
            end
            default: o_ready = 1'b0;
        endcase
    end

    ssl_chain #(
        .ENTRIES (TABLE_ENTRIES)
    ) u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_key   (r_key),
        .i_new   (w_new),
        .o_sts   (w_sts)
    );

    assign w_drop    = w_sts.hit && (w_sts.count >= r_thr);
    assign w_verdict = r_counted && w_drop;

    always_comb begin
        if (!r_counted) begin
            w_count = '0;
        end else if (!w_sts.hit) begin
            w_count = COUNT_W'(1);
        end else if (w_drop) begin
            w_count = w_sts.count;
        end else begin
            w_count = w_sts.count + COUNT_W'(1);
        end
    end

    assign w_new = '{valid: 1'b1, addr: r_key, count: w_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_write) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_verdict <= w_verdict;
            r_count   <= w_count;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_verdict       = r_verdict;
    assign o_tracked_count = r_count;

endmodule

// File: hw/rtl/ssl_cell.sv
// One slot of the recency-ordered source table.
// Compares its key against the lookup address and takes its neighbor's entry on shift.
// Depends on ssl_pkg.
module ssl_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_look,
    input  logic                        i_shift,
    input  logic [ssl_pkg::ADDR_W-1:0]  i_key,
    input  ssl_pkg::t_entry             i_prev,
    output ssl_pkg::t_entry             o_entry,
    output logic                        o_match
);
    import ssl_pkg::*;

    logic               r_valid;
    logic [ADDR_W-1:0]  r_addr;
    logic [COUNT_W-1:0] r_count;
    logic               r_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_prev.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_addr  <= i_prev.addr;
            r_count <= i_prev.count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_look) begin
            r_match <= r_valid && (r_addr == i_key);
        end
    end

    assign o_entry = '{valid: r_valid, addr: r_addr, count: r_count};
    assign o_match = r_match;

endmodule

// File: hw/rtl/ssl_chain.sv
// Row of table cells, most recent at cell 0, with the grouped match reductions
// that give hit, hit count and per-cell shift enables. Depends on ssl_pkg, ssl_cell.
module ssl_chain #(
    parameter int unsigned ENTRIES = ssl_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ssl_pkg::t_chain_ctl         i_ctl,
    input  logic [ssl_pkg::ADDR_W-1:0]  i_key,
    input  ssl_pkg::t_entry             i_new,
    output ssl_pkg::t_chain_sts         o_sts
);
    import ssl_pkg::*;

    localparam int unsigned GROUPS = (ENTRIES + CELLS_PER_GROUP - 1) / CELLS_PER_GROUP;
    localparam int unsigned PADDED = GROUPS * CELLS_PER_GROUP;

    t_entry             w_ent  [ENTRIES];
    logic [PADDED-1:0]  w_match;
    logic [COUNT_W-1:0] w_mcnt [PADDED];
    logic [ENTRIES-1:0] w_shift;

    logic [GROUPS-1:0]  r_gor;
    logic [COUNT_W-1:0] r_gcnt [GROUPS];
    logic [PADDED-1:0]  r_sfx;
    logic [GROUPS-1:0]  n_gor;
    logic [COUNT_W-1:0] n_gcnt [GROUPS];
    logic [PADDED-1:0]  n_sfx;

    logic [GROUPS-1:0]  w_gsfx;
    logic               w_hit;
    logic [COUNT_W-1:0] w_hcnt;

    for (genvar i = 0; i < PADDED; i++) begin : g_cell
        if (i < ENTRIES) begin : g_real
            ssl_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_look  (i_ctl.look),
                .i_shift (w_shift[i]),
                .i_key   (i_key),
                .i_prev  ((i == 0) ? i_new : w_ent[(i == 0) ? 0 : i-1]),
                .o_entry (w_ent[i]),
                .o_match (w_match[i])
            );
            assign w_mcnt[i]  = w_match[i] ? w_ent[i].count : '0;
            // shift when the hit sits at or below this slot, or on a miss
            assign w_shift[i] = i_ctl.upd
                                & (~w_hit | r_sfx[i] | w_gsfx[i / CELLS_PER_GROUP]);
        end else begin : g_pad
            assign w_match[i] = 1'b0;
            assign w_mcnt[i]  = '0;
        end
    end

    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            n_gor[g]  = |w_match[g*CELLS_PER_GROUP +: CELLS_PER_GROUP];
            n_gcnt[g] = '0;
            for (int k = 0; k < CELLS_PER_GROUP; k++) begin
                n_gcnt[g] = n_gcnt[g] | w_mcnt[g*CELLS_PER_GROUP + k];
                n_sfx[g*CELLS_PER_GROUP + k] =
                    |(w_match[g*CELLS_PER_GROUP +: CELLS_PER_GROUP] >> k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.sum) begin
            r_gor  <= n_gor;
            r_gcnt <= n_gcnt;
            r_sfx  <= n_sfx;
        end
    end

    always_comb begin
        w_hcnt = '0;
        for (int g = 0; g < GROUPS; g++) begin
            w_gsfx[g] = |(r_gor >> (g + 1));
            w_hcnt    = w_hcnt | r_gcnt[g];
        end
    end

    assign w_hit = |r_gor;
    assign o_sts = '{hit: w_hit, count: w_hcnt};

endmodule
